// ===== design/voxel_line_of_sight_macros.svh =====
// Assertion macros for the voxel line-of-sight datapath (vlos_dp).
// Each macro expects signals named clk and rst_n in the using module.
`ifndef VOXEL_LINE_OF_SIGHT_MACROS_SVH
`define VOXEL_LINE_OF_SIGHT_MACROS_SVH

// An implication checked on every rising edge outside reset.
`define VLOS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A property that must hold on every rising edge outside reset.
`define VLOS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

// ===== design/vlos_pkg.sv =====
// Package for the voxel line-of-sight block: item types, command and status
// structs, state and outcome codes, and fixed datapath widths. No dependencies.
package vlos_pkg;

  // Internal coordinate width, one bit above the 12-bit item coordinates.
  localparam int CW   = 13;
  // Width of a doubled axis delta.
  localparam int AW   = 13;
  // Width of the Bresenham error terms.
  localparam int ED   = 16;
  // Width of the budget product and of the running limit.
  localparam int PW   = 30;
  localparam int LW   = 31;
  // Divider dividend and divisor widths, and its iteration counter.
  localparam int DVW  = 29;
  localparam int DSW  = 13;
  localparam int DCW  = $clog2(DVW);
  // Step counter width.
  localparam int NW   = 12;
  // Penalty offset in the denominator.
  localparam int PenOffset = 16;

  // Voxel states.
  localparam logic [1:0] VX_EMPTY  = 2'd0;
  localparam logic [1:0] VX_SOLID  = 2'd1;
  localparam logic [1:0] VX_TRANSP = 2'd2;
  localparam logic [1:0] VX_UNUSED = 2'd3;

  // Opcodes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_RAY   = 1'b1;

  typedef enum logic [1:0] {
    OC_REACHED = 2'd0,
    OC_ZERO    = 2'd1,
    OC_SOLID   = 2'd2,
    OC_BUDGET  = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DEC,
    ST_WRITE,
    ST_SETUP,
    ST_MUL,
    ST_DIVS,
    ST_DIVL,
    ST_RDM,
    ST_CHKM,
    ST_DIVP,
    ST_ENDC,
    ST_RDV,
    ST_CHKV,
    ST_RDW,
    ST_CHKW,
    ST_RES
  } state_t;

  typedef struct packed {
    logic               opcode;
    logic signed [11:0] start_x;
    logic signed [11:0] start_y;
    logic signed [11:0] start_z;
    logic signed [11:0] end_x;
    logic signed [11:0] end_y;
    logic signed [11:0] end_z;
    logic        [11:0] ray_distance;
    logic signed [15:0] budget;
    logic        [1:0]  voxel_state;
  } in_item_t;

  typedef struct packed {
    logic       visible;
    logic [1:0] outcome;
  } out_item_t;

  typedef struct packed {
    logic     load;
    logic     setup;
    logic     mul;
    logic     div_lim;
    logic     lim_load;
    logic     div_pen;
    logic     pen_apply;
    logic     step_v;
    logic     step_w;
    logic     advance;
    logic     wr;
    logic     clr;
    logic     out_load;
    outcome_t out_code;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_write;
    logic dist_zero;
    logic dom_zero;
    logic vox_solid;
    logic vox_transp;
    logic at_end;
    logic yd_ge;
    logic zd_ge;
    logic div_done;
    logic pen_neg;
    logic out_busy;
  } sts_t;

endpackage

// ===== design/voxel_line_of_sight.sv =====
// Top level of the voxel line-of-sight block: controller plus datapath.
// Depends on vlos_pkg, vlos_ctrl and vlos_dp.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall | in_data  (vlos_pkg::in_item_t)
//  out     | output    | out_valid/out_stall | out_data (vlos_pkg::out_item_t)
//
// After reset a clearing sweep over all 2^(VOL_X_BITS+VOL_Y_BITS+VOL_Z_BITS)
// voxel addresses empties the voxel store; no item is taken until it ends.
// A write item stores its voxel state if it lies inside the volume. A ray
// runs setup and the budget division after it is taken, then steps along
// the dominant axis, with a penalty division for every transparent voxel on
// the dominant path.
// One item is worked at a time; a finished result waits in the output
// register, and the next item is taken while it waits.
module voxel_line_of_sight #(
  parameter int VOL_X_BITS = 7,
  parameter int VOL_Y_BITS = 7,
  parameter int VOL_Z_BITS = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  vlos_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output vlos_pkg::out_item_t out_data
);
  import vlos_pkg::*;

  cmd_t cmd;
  sts_t sts;

  vlos_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  vlos_dp #(
    .XB (VOL_X_BITS),
    .YB (VOL_Y_BITS),
    .ZB (VOL_Z_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== design/vlos_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on vlos_pkg for its widths.
module vlos_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [vlos_pkg::DVW-1:0] dividend,
  input  logic [vlos_pkg::DSW-1:0] divisor,
  output logic [vlos_pkg::DVW-1:0] quotient,
  output logic                     busy,
  output logic                     valid
);
  import vlos_pkg::*;

  logic [DSW-1:0] rem_r, rem_nxt;
  logic [DVW-1:0] quo_r, quo_nxt;
  logic [DSW-1:0] dsr_r;
  logic [DCW-1:0] cnt_r;
  logic           busy_r, valid_r;
  logic [DSW:0]   rem_sh;
  logic           ge;

  // One shift-and-subtract step of the restoring division.
  always_comb begin
    rem_sh  = {rem_r, quo_r[DVW-1]};
    ge      = rem_sh >= {1'b0, dsr_r};
    rem_nxt = ge ? DSW'(rem_sh - {1'b0, dsr_r}) : rem_sh[DSW-1:0];
    quo_nxt = {quo_r[DVW-2:0], ge};
  end

  // Control: start loads the operands, the count runs DVW steps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else if (start) begin
      busy_r  <= 1'b1;
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DCW'(DVW - 1)) begin
        busy_r  <= 1'b0;
        valid_r <= 1'b1;
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient = quo_r;
  assign busy     = busy_r;
  assign valid    = valid_r;

endmodule

// ===== design/vlos_dp.sv =====
// Datapath of the voxel line-of-sight block: item register, ray walk
// registers, voxel store, budget arithmetic and result register.
// Depends on vlos_pkg, vlos_div and voxel_line_of_sight_macros.svh.
module vlos_dp #(
  parameter int XB = 7,
  parameter int YB = 7,
  parameter int ZB = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vlos_pkg::in_item_t   in_data,
  output vlos_pkg::out_item_t  out_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  vlos_pkg::cmd_t       cmd,
  output vlos_pkg::sts_t       sts
);
  import vlos_pkg::*;
  `include "voxel_line_of_sight_macros.svh"

  localparam int AB = XB + YB + ZB;

  in_item_t item_r;

  logic signed [CW-1:0] dx, dy, dz, sx, sy, sz;
  logic        [AW-1:0] ax, ay, az;
  axis_t                sel_nxt;

  logic signed [CW-1:0] cu_r, cv_r, cw_r, eu_r, su_r, sv_r, sw_r;
  logic        [AW-1:0] au_r, av_r, aw_r;
  logic signed [ED-1:0] yd_r, zd_r;
  axis_t                sel_r;
  logic        [NW-1:0] n_r;

  logic signed [PW-1:0] prod_r;
  logic signed [LW-1:0] limit_r, lim_sub;
  logic        [DVW-1:0] prod_mag, div_dvd, div_q;
  logic        [DSW-1:0] div_dsr;
  logic                  div_busy, div_valid;

  logic signed [CW-1:0] px, py, pz, wx, wy, wz;
  logic                 r_inv, w_inv, inv_r;
  logic [AB-1:0]        rd_addr, wr_addr, mem_wa, clr_cnt_r;
  logic [1:0]           mem_wd, rd_r, wstate;
  logic                 mem_we;
  logic [1:0]           mem [2**AB];

  logic      out_valid_r;
  out_item_t out_data_r;

  // Item register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
  end

  // Axis deltas, doubled magnitudes, step signs and the dominant axis (ties go to x, then y).
  always_comb begin
    dx = CW'(item_r.end_x) - CW'(item_r.start_x);
    dy = CW'(item_r.end_y) - CW'(item_r.start_y);
    dz = CW'(item_r.end_z) - CW'(item_r.start_z);
    ax = dx[CW-1] ? AW'((-dx) <<< 1) : AW'(dx <<< 1);
    ay = dy[CW-1] ? AW'((-dy) <<< 1) : AW'(dy <<< 1);
    az = dz[CW-1] ? AW'((-dz) <<< 1) : AW'(dz <<< 1);
    sx = (dx == '0) ? CW'(0) : (dx[CW-1] ? -CW'(1) : CW'(1));
    sy = (dy == '0) ? CW'(0) : (dy[CW-1] ? -CW'(1) : CW'(1));
    sz = (dz == '0) ? CW'(0) : (dz[CW-1] ? -CW'(1) : CW'(1));
    if (ax >= ay && ax >= az) begin
      sel_nxt = AX_X;
    end else if (ay >= az) begin
      sel_nxt = AX_Y;
    end else begin
      sel_nxt = AX_Z;
    end
  end

  // Walk registers: set up in the axis order, then stepped.
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      sel_r <= sel_nxt;
      n_r   <= '0;
      unique case (sel_nxt)
        AX_Y: begin
          cu_r <= CW'(item_r.start_y); cv_r <= CW'(item_r.start_z);
          cw_r <= CW'(item_r.start_x); eu_r <= CW'(item_r.end_y);
          su_r <= sy; sv_r <= sz; sw_r <= sx;
          au_r <= ay; av_r <= az; aw_r <= ax;
          yd_r <= $signed({3'b0, az}) - $signed({4'b0, ay[AW-1:1]});
          zd_r <= $signed({3'b0, ax}) - $signed({4'b0, ay[AW-1:1]});
        end
        AX_Z: begin
          cu_r <= CW'(item_r.start_z); cv_r <= CW'(item_r.start_x);
          cw_r <= CW'(item_r.start_y); eu_r <= CW'(item_r.end_z);
          su_r <= sz; sv_r <= sx; sw_r <= sy;
          au_r <= az; av_r <= ax; aw_r <= ay;
          yd_r <= $signed({3'b0, ax}) - $signed({4'b0, az[AW-1:1]});
          zd_r <= $signed({3'b0, ay}) - $signed({4'b0, az[AW-1:1]});
        end
        default: begin
          cu_r <= CW'(item_r.start_x); cv_r <= CW'(item_r.start_y);
          cw_r <= CW'(item_r.start_z); eu_r <= CW'(item_r.end_x);
          su_r <= sx; sv_r <= sy; sw_r <= sz;
          au_r <= ax; av_r <= ay; aw_r <= az;
          yd_r <= $signed({3'b0, ay}) - $signed({4'b0, ax[AW-1:1]});
          zd_r <= $signed({3'b0, az}) - $signed({4'b0, ax[AW-1:1]});
        end
      endcase
    end else if (cmd.step_v) begin
      cv_r <= cv_r + sv_r;
      yd_r <= yd_r - $signed({3'b0, au_r});
    end else if (cmd.step_w) begin
      cw_r <= cw_r + sw_r;
      zd_r <= zd_r - $signed({3'b0, au_r});
    end else if (cmd.advance) begin
      cu_r <= cu_r + su_r;
      yd_r <= yd_r + $signed({3'b0, av_r});
      zd_r <= zd_r + $signed({3'b0, aw_r});
      n_r  <= n_r + 1'b1;
    end
  end

  // Budget scaled by the doubled dominant delta, then divided by the distance.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PW'(item_r.budget * $signed({1'b0, au_r}));
    end
  end

  assign prod_mag = prod_r[PW-1] ? DVW'(-prod_r) : DVW'(prod_r);

  // Shared divider: budget scaling or the per-step transparency penalty.
  always_comb begin
    if (cmd.div_pen) begin
      div_dvd = DVW'({n_r, 7'b0});
      div_dsr = DSW'(n_r) + DSW'(PenOffset);
    end else begin
      div_dvd = prod_mag;
      div_dsr = DSW'(item_r.ray_distance);
    end
  end

  vlos_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_lim | cmd.div_pen),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .quotient (div_q),
    .busy     (div_busy),
    .valid    (div_valid)
  );

  assign lim_sub = limit_r - $signed(LW'(div_q));

  // Running limit.
  always_ff @(posedge clk) begin
    if (cmd.lim_load) begin
      limit_r <= prod_r[PW-1] ? -$signed(LW'(div_q)) : $signed(LW'(div_q));
    end else if (cmd.pen_apply) begin
      limit_r <= lim_sub;
    end
  end

  // Current walk position back in x, y, z order, volume bounds tests and store addresses.
  always_comb begin
    unique case (sel_r)
      AX_Y:    begin px = cw_r; py = cu_r; pz = cv_r; end
      AX_Z:    begin px = cv_r; py = cw_r; pz = cu_r; end
      default: begin px = cu_r; py = cv_r; pz = cw_r; end
    endcase
    wx = CW'(item_r.start_x);
    wy = CW'(item_r.start_y);
    wz = CW'(item_r.start_z);
    r_inv = !px[CW-1] && ((px[CW-2:0] >> XB) == '0) &&
            !py[CW-1] && ((py[CW-2:0] >> YB) == '0) &&
            !pz[CW-1] && ((pz[CW-2:0] >> ZB) == '0);
    w_inv = !wx[CW-1] && ((wx[CW-2:0] >> XB) == '0) &&
            !wy[CW-1] && ((wy[CW-2:0] >> YB) == '0) &&
            !wz[CW-1] && ((wz[CW-2:0] >> ZB) == '0);
    rd_addr = {pz[ZB-1:0], py[YB-1:0], px[XB-1:0]};
    wr_addr = {wz[ZB-1:0], wy[YB-1:0], wx[XB-1:0]};
    wstate  = (item_r.voxel_state == VX_UNUSED) ? VX_EMPTY : item_r.voxel_state;
    mem_we  = cmd.clr | (cmd.wr & w_inv);
    mem_wa  = cmd.clr ? clr_cnt_r : wr_addr;
    mem_wd  = cmd.clr ? VX_EMPTY : wstate;
  end

  // Clearing sweep address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Voxel store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r  <= mem[rd_addr];
    inv_r <= r_inv;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.visible <= (cmd.out_code == OC_REACHED) || (cmd.out_code == OC_ZERO);
      out_data_r.outcome <= cmd.out_code;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status toward the controller.
  always_comb begin
    sts.clr_last   = &clr_cnt_r;
    sts.is_write   = (item_r.opcode == OP_WRITE);
    sts.dist_zero  = (item_r.ray_distance == '0);
    sts.dom_zero   = (au_r == '0);
    sts.vox_solid  = inv_r && (rd_r == VX_SOLID);
    sts.vox_transp = inv_r && (rd_r == VX_TRANSP);
    sts.at_end     = (cu_r == eu_r);
    sts.yd_ge      = !yd_r[ED-1];
    sts.zd_ge      = !zd_r[ED-1];
    sts.div_done   = div_valid;
    sts.pen_neg    = lim_sub[LW-1];
    sts.out_busy   = out_valid_r && out_stall;
  end

  `VLOS_ASSERT_IMP(a_no_overwrite, cmd.out_load, !(out_valid_r && out_stall), "result overwritten while stalled")
  `VLOS_ASSERT_IMP(a_div_free, cmd.div_lim || cmd.div_pen, !div_busy, "divider started while busy")
  `VLOS_ASSERT_ALWAYS(a_one_move, $onehot0({cmd.step_v, cmd.step_w, cmd.advance, cmd.setup}), "several walk updates in one cycle")
  `VLOS_ASSERT_IMP(a_clear_alone, cmd.clr, !cmd.wr && !cmd.out_load && !cmd.load, "activity during clearing sweep")

endmodule

// ===== design/vlos_ctrl.sv =====
// Controller state machine of the voxel line-of-sight block.
// Depends on vlos_pkg; drives the datapath through cmd_t and reads sts_t.
module vlos_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  vlos_pkg::sts_t sts,
  output vlos_pkg::cmd_t cmd
);
  import vlos_pkg::*;

  state_t   state_r, state_nxt;
  outcome_t code_r, code_nxt;

  // State and pending outcome registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      code_r  <= OC_REACHED;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    code_nxt     = code_r;
    cmd          = '0;
    cmd.out_code = code_r;
    in_stall     = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        if (sts.is_write) begin
          state_nxt = ST_WRITE;
        end else if (sts.dist_zero) begin
          code_nxt  = OC_ZERO;
          state_nxt = ST_RES;
        end else begin
          state_nxt = ST_SETUP;
        end
      end
      ST_WRITE: begin
        cmd.wr    = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (sts.dom_zero) begin
          code_nxt  = OC_REACHED;
          state_nxt = ST_RES;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = ST_DIVS;
        end
      end
      ST_DIVS: begin
        cmd.div_lim = 1'b1;
        state_nxt   = ST_DIVL;
      end
      ST_DIVL: begin
        if (sts.div_done) begin
          cmd.lim_load = 1'b1;
          state_nxt    = ST_RDM;
        end
      end
      ST_RDM: begin
        state_nxt = ST_CHKM;
      end
      // Main voxel of the step.
      ST_CHKM: begin
        if (sts.vox_solid) begin
          code_nxt  = OC_SOLID;
          state_nxt = ST_RES;
        end else if (sts.vox_transp) begin
          cmd.div_pen = 1'b1;
          state_nxt   = ST_DIVP;
        end else begin
          state_nxt = ST_ENDC;
        end
      end
      ST_DIVP: begin
        if (sts.div_done) begin
          if (sts.pen_neg) begin
            code_nxt  = OC_BUDGET;
            state_nxt = ST_RES;
          end else begin
            cmd.pen_apply = 1'b1;
            state_nxt     = ST_ENDC;
          end
        end
      end
      // End test, then side steps on the minor axes.
      ST_ENDC: begin
        if (sts.at_end) begin
          code_nxt  = OC_REACHED;
          state_nxt = ST_RES;
        end else if (sts.yd_ge) begin
          cmd.step_v = 1'b1;
          state_nxt  = ST_RDV;
        end else if (sts.zd_ge) begin
          cmd.step_w = 1'b1;
          state_nxt  = ST_RDW;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = ST_RDM;
        end
      end
      ST_RDV: begin
        state_nxt = ST_CHKV;
      end
      ST_CHKV: begin
        if (sts.vox_solid) begin
          code_nxt  = OC_SOLID;
          state_nxt = ST_RES;
        end else if (sts.zd_ge) begin
          cmd.step_w = 1'b1;
          state_nxt  = ST_RDW;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = ST_RDM;
        end
      end
      ST_RDW: begin
        state_nxt = ST_CHKW;
      end
      ST_CHKW: begin
        if (sts.vox_solid) begin
          code_nxt  = OC_SOLID;
          state_nxt = ST_RES;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = ST_RDM;
        end
      end
      ST_RES: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
